### design/status_led_rail_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the status rail controller
// Immediate-free concurrent assertion wrappers, removed under SYNTH.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_RAIL_CONTROLLER_MACROS_SVH
`define STATUS_LED_RAIL_CONTROLLER_MACROS_SVH
`ifndef SYNTH
`define SLR_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define SLR_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`else
`define SLR_ASSERT_IMP(label, clk, rst, a, c)
`define SLR_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

### design/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Types and constants shared by the status rail controller.
// ----------------------------------------------------------------------------
package slr_pkg;
  localparam int PixelCount = 6;
  localparam int PixW = 3;
  localparam int HostPixel = 4;

  localparam logic [2:0] OP_REPORT = 3'd0;
  localparam logic [2:0] OP_FRAME = 3'd1;
  localparam logic [2:0] OP_TICK = 3'd2;
  localparam logic [2:0] OP_BLACKOUT = 3'd3;
  localparam logic [2:0] OP_WAKE = 3'd4;
  localparam logic [2:0] OP_OTA_ENTER = 3'd5;
  localparam logic [2:0] OP_OTA_LEAVE = 3'd6;

  localparam logic [1:0] REG_CAP = 2'd0;
  localparam logic [1:0] REG_LATCH = 2'd1;
  localparam logic [1:0] REG_FAST = 2'd2;
  localparam logic [1:0] REG_SLOW = 2'd3;

  localparam logic [1:0] MODE_SOLID = 2'd0;
  localparam logic [1:0] MODE_FAST = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;

  localparam logic [31:0] COL_RED = 32'hFF000000;
  localparam logic [31:0] COL_AMBER = 32'hFF8C0000;
  localparam logic [31:0] COL_PURPLE = 32'h5A00FF00;
  localparam logic [31:0] COL_BLUE = 32'h0000FF00;
  localparam logic [31:0] COL_GREEN = 32'h00FF0000;
  localparam logic [31:0] COL_FAINT = 32'h00000078;

  // per-pixel record: shown, blink colour, mode, latch, prior uptime
  localparam int EntW = 32 + 32 + 2 + 12 + 32;

  typedef struct packed {
    logic [31:0] shown;
    logic [31:0] blink;
    logic [1:0]  mode;
    logic [11:0] latch;
    logic [31:0] uptime;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  member_id;
    logic        alive;
    logic        eligible;
    logic        serving;
    logic        updating;
    logic        is_self;
    logic [31:0] uptime;
    logic [2:0]  leader;
    logic        bench_valid;
    logic [7:0]  bench_bits;
  } item_t;

  typedef struct packed {
    logic [2:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       last;
  } result_t;

  // v * cap / 255 for v, cap < 256: (p + (p>>8) + 1) >> 8 is exact
  function automatic logic [7:0] scale(input logic [7:0] v, input logic [7:0] cap);
    logic [15:0] p;
    logic [16:0] s;
    p = v * cap;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction
endpackage

### design/status_led_rail_controller.sv
// ----------------------------------------------------------------------------
// status_led_rail_controller
// Six-pixel RGBW status rail driven by member reports, frame ends and ticks.
// ----------------------------------------------------------------------------
// One command at a time. start is taken when busy is low. A report is one
// read-modify-write of the pixel record memory and keeps busy high through
// its read and write states. Wake, OTA leave, an ignored command and an OTA
// enter already inside the window finish at the accepting edge. A first OTA
// enter walks the six records, a read and a write state per pixel, and emits
// nothing. A frame end, tick or blackout walks the six pixel records through
// the one memory read port, a read and a write state per pixel, and then
// emits six pixels at one per cycle, 0 to 5, strobe high for exactly one
// cycle each, last on pixel 5; the receiver cannot stall, so results are never
// held. A tick that flips no phase, or touches no blinking pixel, emits
// nothing after its walk. After reset the block clears the six pixel records
// with busy high; configuration writes are accepted at any time (ready is
// tied high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module status_led_rail_controller (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  slr_pkg::item_t           item,
  output logic                     result_valid,
  output slr_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [11:0]              cfg_data
);
  import slr_pkg::*;
  `include "status_led_rail_controller_macros.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WR, S_FRD, S_FWR, S_TRD, S_TWR, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state;
  item_t  cmd;
  logic [PixW-1:0] idx;
  logic [7:0]  cap_level;
  logic [11:0] latch_ticks;
  logic [5:0]  fast_half, slow_half;
  logic [5:0]  reported_mask;
  logic        heard_flag, dark_flag, ota_flag;
  logic [5:0]  fast_count, slow_count;
  logic [1:0]  phase_bits;
  logic        touched, flipped;

  // memory ports
  logic            we;
  logic [PixW-1:0] waddr, raddr;
  entry_t          wdata, rdata;

  slr_ram #(.Width(EntW), .Depth(PixelCount)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAP:   cap_level <= cfg_data[7:0];
        REG_LATCH: latch_ticks <= cfg_data;
        REG_FAST:  fast_half <= cfg_data[5:0];
        REG_SLOW:  slow_half <= cfg_data[5:0];
        default: ;
      endcase
    end
    if (rst) begin
      cap_level <= 8'd50;
      latch_ticks <= 12'd150;
      fast_half <= 6'd3;
      slow_half <= 6'd10;
    end
  end

  // report decode
  logic            mapped;
  logic [PixW-1:0] rep_pix;
  always_comb begin
    mapped = 1'b1;
    rep_pix = '0;
    unique case (cmd.member_id)
      3'd1, 3'd2, 3'd3, 3'd4: rep_pix = cmd.member_id - 3'd1;
      3'd6: rep_pix = PixW'(HostPixel);
      3'd7: rep_pix = 3'd5;
      default: mapped = 1'b0;
    endcase
  end

  entry_t rep_e;
  always_comb begin
    logic booting, benched;
    logic [11:0] lat;
    rep_e = rdata;
    lat = cmd.updating ? latch_ticks : rdata.latch;
    if (cmd.uptime < rdata.uptime) lat = '0;
    booting = cmd.alive && cmd.eligible && !cmd.serving;
    benched = cmd.alive && cmd.eligible && (cmd.member_id != cmd.leader) &&
              cmd.bench_valid && cmd.bench_bits[cmd.member_id];
    rep_e.latch = lat;
    rep_e.uptime = cmd.uptime;
    rep_e.mode = MODE_SOLID;
    if (!cmd.alive) rep_e.blink = COL_RED;
    else if (booting) begin rep_e.blink = COL_AMBER; rep_e.mode = MODE_FAST; end
    else if (lat != '0) begin rep_e.blink = COL_AMBER; rep_e.mode = MODE_SLOW; end
    else if (cmd.member_id == 3'd7) rep_e.blink = COL_PURPLE;
    else if (cmd.member_id == 3'd6) rep_e.blink = COL_BLUE;
    else if (cmd.member_id == cmd.leader) rep_e.blink = COL_GREEN;
    else if (benched) rep_e.blink = COL_AMBER;
    else if (cmd.eligible) rep_e.blink = COL_FAINT;
    else rep_e.blink = COL_PURPLE;
    rep_e.shown = rep_e.blink;
  end

  // frame end / blackout / ota per-pixel update
  entry_t frm_e;
  always_comb begin
    frm_e = rdata;
    unique case (cmd.operation)
      OP_FRAME: begin
        if (!reported_mask[idx]) frm_e.shown = '0;
        if (idx == PixW'(HostPixel)) begin
          frm_e.mode = MODE_SOLID;
          frm_e.shown = heard_flag ? COL_BLUE : COL_RED;
        end
      end
      OP_BLACKOUT: begin
        frm_e.mode = MODE_SOLID;
        frm_e.shown = '0;
      end
      OP_OTA_ENTER: begin
        frm_e.mode = MODE_SLOW;
        frm_e.blink = COL_AMBER;
      end
      default: ;
    endcase
  end

  // tick per-pixel update; phase_bits already updated
  entry_t tck_e;
  logic   tck_blink;
  always_comb begin
    logic on;
    tck_e = rdata;
    if (rdata.latch != '0) tck_e.latch = rdata.latch - 12'd1;
    tck_blink = flipped && !dark_flag && (rdata.mode != MODE_SOLID);
    on = (rdata.mode == MODE_FAST) ? phase_bits[0] : phase_bits[1];
    if (tck_blink) tck_e.shown = on ? rdata.blink : '0;
  end

  // blink counters
  logic [5:0] fc_inc, sc_inc, fh, sh;
  logic       fwrap, swrap;
  always_comb begin
    fh = (fast_half == '0) ? 6'd1 : fast_half;
    sh = (slow_half == '0) ? 6'd1 : slow_half;
    fc_inc = fast_count + 6'd1;
    sc_inc = slow_count + 6'd1;
    fwrap = (fc_inc >= fh);
    swrap = (sc_inc >= sh);
  end

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = frm_e;
    raddr = idx;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_RD: raddr = rep_pix;
      S_WR: begin
        we = 1'b1;
        wdata = (cmd.operation == OP_REPORT) ? rep_e : frm_e;
      end
      S_FWR: we = 1'b1;
      S_TWR: begin
        we = 1'b1;
        wdata = tck_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    unique case (state)
      S_CLEAR: begin
        idx <= idx + 3'd1;
        if (idx == PixW'(PixelCount - 1)) begin
          state <= S_IDLE;
          idx <= '0;
        end
      end
      S_IDLE: begin
        idx <= '0;
        if (start) begin
          cmd <= item;
          unique case (item.operation)
            OP_REPORT: begin
              if (!dark_flag && !ota_flag) begin
                if (!item.is_self && item.alive) heard_flag <= 1'b1;
                state <= S_RD;
              end
            end
            OP_FRAME: if (!dark_flag && !ota_flag) state <= S_FRD;
            OP_TICK: begin
              fast_count <= fwrap ? '0 : fc_inc;
              slow_count <= swrap ? '0 : sc_inc;
              phase_bits <= phase_bits ^ {swrap, fwrap};
              flipped <= fwrap || swrap;
              touched <= 1'b0;
              state <= S_TRD;
            end
            OP_BLACKOUT: begin
              dark_flag <= 1'b1;
              state <= S_FRD;
            end
            OP_WAKE: dark_flag <= 1'b0;
            OP_OTA_ENTER: begin
              ota_flag <= 1'b1;
              if (!ota_flag) state <= S_FRD;
            end
            OP_OTA_LEAVE: ota_flag <= 1'b0;
            default: ;
          endcase
        end
      end
      S_RD: begin
        // rdata valid next; report pixel held in idx
        idx <= rep_pix;
        state <= mapped ? S_WR : S_IDLE;
      end
      S_WR: begin
        reported_mask[idx] <= 1'b1;
        state <= S_IDLE;
      end
      S_FRD: state <= S_FWR;
      S_FWR: begin
        idx <= idx + 3'd1;
        state <= S_FRD;
        if (idx == PixW'(PixelCount - 1)) begin
          idx <= '0;
          if (cmd.operation == OP_FRAME) begin
            reported_mask <= '0;
            heard_flag <= 1'b0;
          end
          state <= (cmd.operation == OP_OTA_ENTER) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_TRD: state <= S_TWR;
      S_TWR: begin
        if (tck_blink) touched <= 1'b1;
        idx <= idx + 3'd1;
        state <= S_TRD;
        if (idx == PixW'(PixelCount - 1)) begin
          idx <= '0;
          state <= (touched || tck_blink) ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: begin
        idx <= idx + 3'd1;
        state <= S_EMIT;
      end
      S_EMIT: begin
        // rdata holds pixel idx-1
        result_valid <= 1'b1;
        result.pixel <= idx - 3'd1;
        result.red <= scale(rdata.shown[31:24], cap_level);
        result.green <= scale(rdata.shown[23:16], cap_level);
        result.blue <= scale(rdata.shown[15:8], cap_level);
        result.white <= scale(rdata.shown[7:0], cap_level);
        result.last <= (idx == PixW'(PixelCount));
        idx <= idx + 3'd1;
        if (idx == PixW'(PixelCount)) begin
          state <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      result_valid <= 1'b0;
      reported_mask <= '0;
      heard_flag <= 1'b0;
      dark_flag <= 1'b0;
      ota_flag <= 1'b0;
      fast_count <= '0;
      slow_count <= '0;
      phase_bits <= 2'b11;
      flipped <= 1'b0;
      touched <= 1'b0;
    end
  end

  `SLR_ASSERT_IMP(a_emit_busy, clk, rst, result_valid, busy || $past(state) == S_EMIT)
  `SLR_ASSERT_IMP(a_last_pix, clk, rst, result_valid && result.last, result.pixel == 3'd5)
  `SLR_ASSERT_NXT(a_start_idle, clk, rst, start && !busy && item.operation == OP_TICK, busy)
  `SLR_ASSERT_IMP(a_pix_range, clk, rst, result_valid, result.pixel <= 3'd5)
endmodule

### design/slr_ram.sv
// ----------------------------------------------------------------------------
// slr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slr_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### dv/tb_status_led_rail_controller.sv
// ----------------------------------------------------------------------------
// tb_status_led_rail_controller
// Self-checking bench for the six-pixel status rail: a directed table, then
// random report/frame/tick traffic under several register settings. Every
// emitted pixel is checked against an in-bench prediction of the rail.
// ----------------------------------------------------------------------------
module tb_status_led_rail_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import slr_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;  // undefined opcode, must be ignored
  localparam int IdleLimit = 3000;          // cycles with no transaction at all
  localparam int RandPerSetting = 68;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_CAP;
  logic [11:0] cfg_data = '0;

  status_led_rail_controller dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Rail prediction: register copies and per-pixel state
  // --------------------------------------------------------------------------
  int unsigned cap_r, latch_r, fast_r, slow_r;
  logic [31:0] rail_shown [PixelCount];
  logic [31:0] rail_blink [PixelCount];
  logic [1:0]  rail_mode  [PixelCount];
  logic [11:0] rail_latch [PixelCount];
  logic [31:0] rail_up    [PixelCount];
  logic [5:0]  reported;
  bit          heard, dark, ota;
  logic [5:0]  fast_cnt, slow_cnt;
  logic [1:0]  phase;          // bit0 fast, bit1 slow

  result_t pixels_due[$];      // pixels the rail owes, oldest first
  int      fails = 0;

  function automatic int pixel_of(logic [2:0] id);
    if (id >= 3'd1 && id <= 3'd4) return int'(id) - 1;
    if (id == 3'd6) return HostPixel;
    if (id == 3'd7) return 5;
    return -1;
  endfunction

  function automatic logic [7:0] capped(logic [7:0] v);
    int unsigned p;
    p = (int'(v) * cap_r) / 255;
    return p[7:0];
  endfunction

  task automatic push_frame();
    result_t r;
    for (int i = 0; i < PixelCount; i++) begin
      r.pixel = i[2:0];
      r.red   = capped(rail_shown[i][31:24]);
      r.green = capped(rail_shown[i][23:16]);
      r.blue  = capped(rail_shown[i][15:8]);
      r.white = capped(rail_shown[i][7:0]);
      r.last  = (i == PixelCount - 1);
      pixels_due.push_back(r);
    end
  endtask

  // counter wraps at 6 bits; a half period of zero fires every tick
  function automatic bit phase_step(ref logic [5:0] cnt, input int unsigned half);
    cnt = cnt + 6'd1;
    if (cnt >= half) begin
      cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic apply_report(item_t it);
    int p;
    logic [31:0] col;
    logic [1:0] md;
    bit booting, benched;
    md = MODE_SOLID;
    if (!it.is_self && it.alive) heard = 1'b1;
    p = pixel_of(it.member_id);
    if (p < 0) return;
    if (it.updating) rail_latch[p] = latch_r[11:0];
    if (it.uptime < rail_up[p]) rail_latch[p] = '0;   // reboot wins over updating
    rail_up[p] = it.uptime;
    booting = it.alive && it.eligible && !it.serving;
    benched = it.alive && it.eligible && it.member_id != it.leader && it.bench_valid
              && it.bench_bits[it.member_id];
    if (!it.alive) col = COL_RED;
    else if (booting) begin
      col = COL_AMBER;
      md = MODE_FAST;
    end else if (rail_latch[p] != 0) begin
      col = COL_AMBER;
      md = MODE_SLOW;
    end else if (it.member_id == 3'd7) col = COL_PURPLE;
    else if (it.member_id == 3'd6) col = COL_BLUE;
    else if (it.member_id == it.leader) col = COL_GREEN;
    else if (benched) col = COL_AMBER;
    else if (it.eligible) col = COL_FAINT;
    else col = COL_PURPLE;
    rail_mode[p] = md;
    rail_blink[p] = col;
    rail_shown[p] = col;
    reported[p] = 1'b1;
  endtask

  task automatic predict_rail(item_t it);
    bit flipped, touched, on;
    flipped = 1'b0;
    touched = 1'b0;
    case (it.operation)
      OP_REPORT: if (!dark && !ota) apply_report(it);
      OP_FRAME: if (!dark && !ota) begin
        for (int i = 0; i < PixelCount; i++)
          if (!reported[i]) rail_shown[i] = '0;
        rail_mode[HostPixel] = MODE_SOLID;
        rail_shown[HostPixel] = heard ? COL_BLUE : COL_RED;
        reported = '0;
        heard = 1'b0;
        push_frame();
      end
      OP_TICK: begin
        for (int i = 0; i < PixelCount; i++)
          if (rail_latch[i] != 0) rail_latch[i]--;
        if (phase_step(fast_cnt, fast_r)) begin
          phase[0] = ~phase[0];
          flipped = 1'b1;
        end
        if (phase_step(slow_cnt, slow_r)) begin
          phase[1] = ~phase[1];
          flipped = 1'b1;
        end
        if (flipped && !dark) begin
          for (int i = 0; i < PixelCount; i++) begin
            if (rail_mode[i] == MODE_SOLID) continue;
            on = (rail_mode[i] == MODE_FAST) ? phase[0] : phase[1];
            rail_shown[i] = on ? rail_blink[i] : '0;
            touched = 1'b1;
          end
          if (touched) push_frame();
        end
      end
      OP_BLACKOUT: begin
        dark = 1'b1;
        for (int i = 0; i < PixelCount; i++) begin
          rail_mode[i] = MODE_SOLID;
          rail_shown[i] = '0;
        end
        push_frame();
      end
      OP_WAKE: dark = 1'b0;
      OP_OTA_ENTER: begin
        if (!ota)
          for (int i = 0; i < PixelCount; i++) begin
            rail_mode[i] = MODE_SLOW;
            rail_blink[i] = COL_AMBER;
          end
        ota = 1'b1;
      end
      OP_OTA_LEAVE: ota = 1'b0;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking: the receiver never stalls, so every strobe is a transaction
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pixels_due.size() == 0) report_mismatch("unexpected pixel", result.pixel, 0);
      else begin
        want = pixels_due.pop_front();
        if (result.pixel !== want.pixel) report_mismatch("pixel", result.pixel, want.pixel);
        if (result.red !== want.red) report_mismatch("red", result.red, want.red);
        if (result.green !== want.green) report_mismatch("green", result.green, want.green);
        if (result.blue !== want.blue) report_mismatch("blue", result.blue, want.blue);
        if (result.white !== want.white) report_mismatch("white", result.white, want.white);
        if (result.last !== want.last) report_mismatch("last", result.last, want.last);
      end
    end
  end

  // watchdog: any command, pixel or register transaction resets it
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb_status_led_rail_controller NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // called at a rising edge; returns at the edge that took the transaction,
  // start left high so the next command may follow back to back
  task automatic send(item_t it);
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_rail(it);
  endtask

  task automatic write_regs(int unsigned cap, int unsigned latch, int unsigned fast,
                            int unsigned slow);
    logic [1:0] idx [4];
    int unsigned val [4];
    idx = '{REG_CAP, REG_LATCH, REG_FAST, REG_SLOW};
    val = '{cap, latch, fast, slow};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k][11:0];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_CAP:   cap_r = val[k] & 8'hFF;
        REG_LATCH: latch_r = val[k] & 12'hFFF;
        REG_FAST:  fast_r = val[k] & 6'h3F;
        default:   slow_r = val[k] & 6'h3F;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // block must be idle before a register write: all pixels in, then enough
  // slack for a silent tick still walking the pixel records
  task automatic drain();
    start <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic item_t mk(logic [2:0] op, logic [2:0] id, bit al, bit el, bit sv,
                               bit up, bit me, logic [31:0] ut, logic [2:0] ld, bit bv,
                               logic [7:0] bm);
    item_t it;
    it = '{op, id, al, el, sv, up, me, ut, ld, bv, bm};
    return it;
  endfunction

  function automatic result_t host_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    result_t x;
    x = '{3'd4, r, g, b, 8'd0, 1'b0};
    return x;
  endfunction

  // random traffic: mostly reports, frame ends and ticks; the rest mode events and the unused opcode
  logic [31:0] last_up [8];
  function automatic item_t rand_item();
    item_t it;
    int w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    w = $urandom_range(0, 99);
    if (w < 52) it.operation = OP_REPORT;
    else if (w < 67) it.operation = OP_FRAME;
    else if (w < 87) it.operation = OP_TICK;
    else if (w < 89) it.operation = OP_BLACKOUT;
    else if (w < 94) it.operation = OP_WAKE;
    else if (w < 96) it.operation = OP_OTA_ENTER;
    else if (w < 99) it.operation = OP_OTA_LEAVE;
    else it.operation = OP_UNUSED;
    it.alive = ($urandom_range(0, 9) != 0);
    it.is_self = ($urandom_range(0, 5) == 0);
    it.updating = ($urandom_range(0, 4) == 0);
    // uptime mostly climbs; sometimes it jumps anywhere, which may be a reboot
    if ($urandom_range(0, 3) != 0) it.uptime = last_up[it.member_id] + $urandom_range(0, 40);
    last_up[it.member_id] = it.uptime;
    return it;
  endfunction

  typedef struct {
    item_t   it;
    bit      pin;    // host pixel value typed in below
    result_t host;
  } row_t;
  row_t plan [];

  int unsigned burst_left;
  initial begin
    cap_r = 50; latch_r = 150; fast_r = 3; slow_r = 10;
    for (int i = 0; i < PixelCount; i++) begin
      rail_shown[i] = '0; rail_blink[i] = '0; rail_mode[i] = MODE_SOLID;
      rail_latch[i] = '0; rail_up[i] = '0;
    end
    reported = '0; heard = 0; dark = 0; ota = 0;
    fast_cnt = '0; slow_cnt = '0; phase = 2'b11;
    for (int i = 0; i < 8; i++) last_up[i] = '0;

    plan = '{
      // nothing heard after reset: host red at cap 50
      '{mk(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, host_px(50, 0, 0)},
      '{mk(OP_REPORT, 0, 1, 0, 0, 0, 0, 32'h10, 0, 0, 0), 0, '0},      // unmapped id
      '{mk(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, host_px(0, 0, 50)},
      '{mk(OP_REPORT, 1, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0), 0, '0}, // lost
      '{mk(OP_REPORT, 2, 1, 1, 0, 0, 0, 5, 0, 0, 0), 0, '0},           // booting
      '{mk(OP_REPORT, 3, 1, 1, 1, 1, 0, 1000, 0, 0, 0), 0, '0},        // release latch
      '{mk(OP_REPORT, 7, 1, 1, 1, 0, 1, 7, 7, 1, 8'hFF), 0, '0},       // id 7, self
      '{mk(OP_REPORT, 6, 1, 0, 1, 0, 0, 6, 0, 0, 0), 0, '0},           // id 6
      '{mk(OP_REPORT, 4, 1, 1, 1, 0, 0, 9, 4, 1, 8'hFF), 0, '0},       // leader
      '{mk(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(OP_REPORT, 1, 1, 1, 1, 0, 0, 32'hFFFFFFFF, 4, 1, 8'hFF), 0, '0}, // benched
      '{mk(OP_REPORT, 2, 1, 1, 1, 0, 0, 6, 4, 0, 8'hFF), 0, '0},       // eligible
      '{mk(OP_REPORT, 4, 1, 0, 1, 0, 0, 10, 7, 0, 0), 0, '0},          // other
      '{mk(OP_REPORT, 3, 1, 1, 1, 1, 0, 0, 0, 0, 0), 0, '0},           // reboot clears latch
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},             // fast flip
      '{mk(OP_BLACKOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, host_px(0, 0, 0)},
      '{mk(OP_REPORT, 1, 1, 1, 1, 0, 0, 50, 0, 0, 0), 0, '0},          // ignored, dark
      '{mk(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},            // ignored, dark
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},             // dark tick
      '{mk(OP_WAKE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(OP_OTA_ENTER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},            // ignored, OTA
      '{mk(OP_OTA_LEAVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(OP_UNUSED, 7, 1, 1, 1, 1, 1, 32'hFFFFFFFF, 7, 1, 8'hFF), 0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      send(plan[k].it);
      // typed host value replaces the predicted one
      if (plan[k].pin) pixels_due[pixels_due.size() - PixelCount + HostPixel] = plan[k].host;
    end

    // register extremes first, then an ordinary mid setting
    for (int s = 0; s < 3; s++) begin
      drain();
      case (s)
        0: write_regs(255, 4095, 1, 63);
        1: write_regs(0, 0, 0, 1);
        default: write_regs(137, 5, 2, 4);
      endcase
      burst_left = 0;
      for (int n = 0; n < RandPerSetting; n++) begin
        send(rand_item());
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else burst_left--;
      end
    end

    start <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("tb_status_led_rail_controller OK");
    else $display("tb_status_led_rail_controller NOT OK");
    $finish;
  end
endmodule
